[hw/rtl/pmsm_speed_loop_model_step_unit_defines.svh]
// assertion macros shared by the speed loop model rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef PMSM_SPEED_LOOP_MODEL_STEP_UNIT_DEFINES_SVH
`define PMSM_SPEED_LOOP_MODEL_STEP_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PSLM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define PSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/pslm_pkg.sv]
// shared widths, constants, codes and helpers of the speed loop model
// no dependencies
package pslm_pkg;

	// data path width of the model signals (signed q16.16)
	localparam int DW = 32;
	// multiplier operand a: exact sum of two data values plus sign
	localparam int AW = DW + 2;
	// multiplier operand b: unsigned gains and constants
	localparam int BW = 32;
	// width for exact sums before saturation
	localparam int XW = ((DW > 32) ? DW : 32) + 2;

	localparam int ADDR_W = 5;
	localparam int IDX_W = 3;

	localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [XW-1:0] MAXV_X = (XW'(1) <<< (DW - 1)) - XW'(1);
	localparam logic signed [XW-1:0] MINV_X = -MAXV_X - XW'(1);
	localparam logic signed [XW-1:0] MAX32_X = (XW'(1) <<< 31) - XW'(1);
	localparam logic signed [XW-1:0] MIN32_X = -MAX32_X - XW'(1);

	// q16.16 and q0.32 constants
	localparam logic signed [DW-1:0] K_ONE = DW'(65536);
	localparam logic [BW-1:0] K_075 = BW'(49152);
	localparam logic [BW-1:0] K_025 = BW'(16384);
	localparam logic [BW-1:0] K_0625 = BW'(40960);
	localparam logic [BW-1:0] K_DT = BW'(2147484);
	localparam logic [BW-1:0] K_KI = BW'(4294967);

	// register indexes
	localparam logic [IDX_W-1:0] REG_FLUX = 3'd0;
	localparam logic [IDX_W-1:0] REG_POLES = 3'd1;
	localparam logic [IDX_W-1:0] REG_INV_J = 3'd2;
	localparam logic [IDX_W-1:0] REG_KP = 3'd3;
	localparam logic [IDX_W-1:0] REG_KI = 3'd4;

	// input operation codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// multiply sequence of one tick
	localparam logic [3:0] STEP_T075 = 4'd0;
	localparam logic [3:0] STEP_TPOLE = 4'd1;
	localparam logic [3:0] STEP_TFLUX = 4'd2;
	localparam logic [3:0] STEP_SDT = 4'd3;
	localparam logic [3:0] STEP_SINVJ = 4'd4;
	localparam logic [3:0] STEP_EP = 4'd5;
	localparam logic [3:0] STEP_OD = 4'd6;
	localparam logic [3:0] STEP_ANG = 4'd7;
	localparam logic [3:0] STEP_CUR = 4'd8;
	localparam logic [3:0] STEP_EI = 4'd9;
	localparam logic [3:0] STEP_KIS = 4'd10;

	typedef enum logic [1:0] {
		SH_0,
		SH_16,
		SH_32
	} sh_t;

	typedef struct packed {
		logic start;
		sh_t sh;
	} mul_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [XW-1:0] x);
		logic signed [DW-1:0] r;
		if (x > MAXV_X) r = MAXV;
		else if (x < MINV_X) r = MINV;
		else r = x[DW-1:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat_32(input logic signed [XW-1:0] x);
		logic signed [31:0] r;
		if (x > MAX32_X) r = 32'sh7FFF_FFFF;
		else if (x < MIN32_X) r = 32'sh8000_0000;
		else r = x[31:0];
		return r;
	endfunction

endpackage

[hw/rtl/pslm_mul.sv]
// bit-serial shift-add multiplier with rounding shift and saturation
// depends on pslm_pkg
module pslm_mul (
	input logic clk,
	input logic arst_n,
	input pslm_pkg::mul_cmd_t cmd,
	input logic signed [pslm_pkg::AW-1:0] op_a,
	input logic [pslm_pkg::BW-1:0] op_b,
	output pslm_pkg::mul_stat_t stat,
	output logic signed [pslm_pkg::DW-1:0] res
);
	import pslm_pkg::*;

	localparam int PW = AW + BW;
	localparam int CW = $clog2(BW);
	localparam logic [PW-1:0] MAG_LIM = PW'(1) << (DW - 1);

	logic run_q, fin_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] ua_q, ua_n;
	logic [PW-1:0] prod_q, shifted, mag;
	logic [AW:0] psum;
	logic rbit;
	sh_t sh_q;
	logic signed [DW-1:0] fin_val;

	assign ua_n = op_a[AW-1] ? (~$unsigned(op_a)) + AW'(1) : $unsigned(op_a);
	// one multiplier bit per cycle, lsb first
	assign psum = {1'b0, prod_q[PW-1:BW]} + (prod_q[0] ? {1'b0, ua_q} : '0);

	always_comb begin
		case (sh_q)
			SH_0: begin
				shifted = prod_q;
				rbit = 1'b0;
			end
			SH_16: begin
				shifted = prod_q >> 16;
				rbit = prod_q[15];
			end
			SH_32: begin
				shifted = prod_q >> 32;
				rbit = prod_q[31];
			end
			default: begin
				shifted = prod_q;
				rbit = 1'b0;
			end
		endcase
		// round half away from zero on the magnitude
		mag = shifted + PW'(rbit);
		if (neg_q) begin
			fin_val = (mag >= MAG_LIM) ? MINV : DW'(0) - mag[DW-1:0];
		end else begin
			fin_val = (mag > MAG_LIM - PW'(1)) ? MAXV : mag[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(BW - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			neg_q <= op_a[AW-1];
			ua_q <= ua_n;
			prod_q <= {{AW{1'b0}}, op_b};
			sh_q <= cmd.sh;
		end else if (run_q) begin
			prod_q <= {psum, prod_q[BW-1:1]};
		end
		if (fin_q) begin
			res <= fin_val;
		end
	end

	assign stat.busy = run_q | fin_q;
	assign stat.done = done_q;

endmodule

[hw/rtl/pmsm_speed_loop_model_step_unit.sv]
// top level of the pmsm speed loop plant model with pi speed control
// depends on pslm_pkg, pslm_mul and the shared assertion macro header

// One item per control tick: operation 0 advances the plant model by one
// sample from load_torque and speed_target and returns motor_speed and
// motor_angle; operation 1 zeroes the five model states and returns zeros.
// All signals are signed q16.16 and every product is rounded half away
// from zero and saturated. The user must write the gains, flux linkage,
// pole pairs and inverse inertia through the apb port only while no item
// is in flight; the block itself does not enforce this. Every product of
// a tick runs through one shared bit-serial multiplier that takes one
// multiplier bit per clock, so a tick is eleven multiplies. item_ready is
// back high in the same cycle that result_valid rises. A clear item goes
// from acceptance straight to the output state.
// One item is worked on at a time; the output register lets the next item
// be accepted while the previous result still waits to be taken.
`include "pmsm_speed_loop_model_step_unit_defines.svh"

module pmsm_speed_loop_model_step_unit (
	input logic clk,
	input logic arst_n,
	// item channel
	input logic item_valid,
	output logic item_ready,
	input logic operation,
	input logic signed [31:0] load_torque,
	input logic signed [31:0] speed_target,
	// result channel
	output logic result_valid,
	input logic result_ready,
	output logic signed [31:0] motor_speed,
	output logic signed [31:0] motor_angle,
	// configuration port
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pslm_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import pslm_pkg::*;

	// sequencer: issue a multiply, wait for it, then hand the result out
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT = 4'b0100,
		ST_OUT = 4'b1000
	} state_t;

	state_t state_q;
	logic [3:0] step_q;

	// configuration registers
	logic [30:0] flux_q, inv_j_q, kp_q, ki_q;
	logic [6:0] poles_q;

	// model state
	logic signed [DW-1:0] clo_q, accel_q, pi_int_q, pi_od_q, angle_dly_q;

	// working values of one tick
	logic signed [DW-1:0] load_q, target_q, t_q, p_q, err_q, e_q, a_q;
	logic signed [DW-1:0] speed_q, angle_q;

	mul_cmd_t mul_cmd;
	mul_stat_t mul_stat;
	logic signed [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic signed [DW-1:0] mul_res;

	logic item_acc, cfg_wr, res_done, out_load, last_step;
	logic [IDX_W-1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr = psel & penable & pwrite & pready;

	assign item_ready = (state_q == ST_IDLE);
	assign item_acc = item_valid & item_ready;
	assign res_done = (state_q == ST_WAIT) & mul_stat.done;
	assign last_step = (step_q == STEP_KIS);
	// output register is free or being emptied this cycle
	assign out_load = (state_q == ST_OUT) & (~result_valid | result_ready);

	// register readback
	always_comb begin
		case (reg_idx)
			REG_FLUX: prdata = {1'b0, flux_q};
			REG_POLES: prdata = {25'd0, poles_q};
			REG_INV_J: prdata = {1'b0, inv_j_q};
			REG_KP: prdata = {1'b0, kp_q};
			REG_KI: prdata = {1'b0, ki_q};
			default: prdata = '0;
		endcase
	end

	// operand selection for each multiply of the tick
	always_comb begin
		mul_cmd.start = (state_q == ST_ISSUE);
		case (step_q)
			STEP_T075: begin
				// 0.75 * (u + 1)
				mul_a = AW'(sat_dw(XW'(clo_q) + XW'(K_ONE)));
				mul_b = K_075;
				mul_cmd.sh = SH_16;
			end
			STEP_TPOLE: begin
				mul_a = AW'(t_q);
				mul_b = BW'(poles_q);
				mul_cmd.sh = SH_0;
			end
			STEP_TFLUX: begin
				mul_a = AW'(t_q);
				mul_b = BW'(flux_q);
				mul_cmd.sh = SH_16;
			end
			STEP_SDT: begin
				// trapezoid on acceleration, sum left unsaturated
				mul_a = AW'(p_q) + AW'(accel_q);
				mul_b = K_DT;
				mul_cmd.sh = SH_32;
			end
			STEP_SINVJ: begin
				mul_a = AW'(t_q);
				mul_b = BW'(inv_j_q);
				mul_cmd.sh = SH_16;
			end
			STEP_EP: begin
				mul_a = AW'(err_q);
				mul_b = BW'(kp_q);
				mul_cmd.sh = SH_16;
			end
			STEP_OD: begin
				mul_a = AW'(pi_od_q);
				mul_b = K_025;
				mul_cmd.sh = SH_16;
			end
			STEP_ANG: begin
				// trapezoid on speed gives the angle
				mul_a = AW'(a_q) + AW'(angle_dly_q);
				mul_b = K_DT;
				mul_cmd.sh = SH_32;
			end
			STEP_CUR: begin
				// lagged current loop
				mul_a = AW'(e_q) + AW'(pi_od_q);
				mul_b = K_0625;
				mul_cmd.sh = SH_16;
			end
			STEP_EI: begin
				mul_a = AW'(err_q);
				mul_b = BW'(ki_q);
				mul_cmd.sh = SH_16;
			end
			STEP_KIS: begin
				mul_a = AW'(t_q);
				mul_b = K_KI;
				mul_cmd.sh = SH_32;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
				mul_cmd.sh = SH_0;
			end
		endcase
	end

	pslm_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(mul_cmd),
		.op_a(mul_a),
		.op_b(mul_b),
		.stat(mul_stat),
		.res(mul_res)
	);

	// control, configuration and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_T075;
			result_valid <= 1'b0;
			flux_q <= '0;
			poles_q <= '0;
			inv_j_q <= '0;
			kp_q <= '0;
			ki_q <= '0;
			clo_q <= '0;
			accel_q <= '0;
			pi_int_q <= '0;
			pi_od_q <= '0;
			angle_dly_q <= '0;
		end else begin
			if (cfg_wr) begin
				case (reg_idx)
					REG_FLUX: flux_q <= pwdata[30:0];
					REG_POLES: poles_q <= pwdata[6:0];
					REG_INV_J: inv_j_q <= pwdata[30:0];
					REG_KP: kp_q <= pwdata[30:0];
					REG_KI: ki_q <= pwdata[30:0];
					default: ;
				endcase
			end

			// output register: set on a new result, cleared when taken
			if (out_load) begin
				result_valid <= 1'b1;
			end else if (result_valid & result_ready) begin
				result_valid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						step_q <= STEP_T075;
						if (operation == OP_CLEAR) begin
							clo_q <= '0;
							accel_q <= '0;
							pi_int_q <= '0;
							pi_od_q <= '0;
							angle_dly_q <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mul_stat.done) begin
						if (step_q == STEP_CUR) begin
							clo_q <= mul_res;
						end
						if (last_step) begin
							// commit the delay and integrator states
							accel_q <= p_q;
							pi_int_q <= sat_dw(XW'(pi_int_q) + XW'(mul_res));
							pi_od_q <= e_q;
							angle_dly_q <= a_q;
							state_q <= ST_OUT;
						end else begin
							step_q <= step_q + 4'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working values and output payload
	always_ff @(posedge clk) begin
		if (item_acc) begin
			load_q <= sat_dw(XW'(load_torque));
			target_q <= sat_dw(XW'(speed_target));
			if (operation == OP_CLEAR) begin
				speed_q <= '0;
				angle_q <= '0;
			end
		end
		if (res_done) begin
			case (step_q)
				STEP_TFLUX: begin
					// p = sat(sat(torque - load) + accel_delay)
					p_q <= sat_dw(XW'(sat_dw(XW'(mul_res) - XW'(load_q))) + XW'(accel_q));
				end
				STEP_SINVJ: begin
					speed_q <= mul_res;
					err_q <= sat_dw(XW'(target_q) - XW'(mul_res));
					a_q <= sat_dw(XW'(mul_res) + XW'(angle_dly_q));
				end
				STEP_OD: begin
					// pi output: err*kp + integral - 0.25*previous output
					e_q <= sat_dw(XW'(t_q) + XW'(pi_int_q) - XW'(mul_res));
				end
				STEP_ANG: begin
					angle_q <= mul_res;
				end
				default: begin
					t_q <= mul_res;
				end
			endcase
		end
		if (out_load) begin
			motor_speed <= sat_32(XW'(speed_q));
			motor_angle <= sat_32(XW'(angle_q));
		end
	end

	`PSLM_ASSERT_NOW(a_issue_mul_free, state_q == ST_ISSUE, !mul_stat.busy,
		"multiply issued while the multiplier is still busy")
	`PSLM_ASSERT_NOW(a_done_in_wait, mul_stat.done, state_q == ST_WAIT,
		"multiplier result arrived outside the wait state")
	`PSLM_ASSERT_NOW(a_no_accept_busy, mul_stat.busy, !item_ready,
		"item ready while a multiply is in flight")
	`PSLM_ASSERT_NEXT(a_clear_zeroes,
		item_valid && item_ready && operation == OP_CLEAR,
		state_q == ST_OUT && accel_q == '0 && pi_int_q == '0 && angle_dly_q == '0,
		"clear item did not zero the model state")

endmodule

[tb/sv/tb.sv]
// self-checking testbench for pmsm_speed_loop_model_step_unit
// drives items over valid/ready, registers over apb, checks against an inline q16.16 plant model
// depends on pslm_pkg and the rtl of the speed loop model
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pslm_pkg::*;

	// signal range of the model data path
	localparam int SIG_W = pslm_pkg::DW;
	localparam longint SIG_MAX = (64'sd1 <<< (SIG_W - 1)) - 64'sd1;
	localparam longint SIG_MIN = -SIG_MAX - 64'sd1;
	// an index past the last register, writes to it must change nothing
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd5;
	// final wait at the end of the run, a margin for late or extra results
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic signed [31:0] speed;
		logic signed [31:0] angle;
	} rotor_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_ready;
	logic operation = OP_TICK;
	logic signed [31:0] load_torque = '0;
	logic signed [31:0] speed_target = '0;

	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [31:0] motor_speed;
	logic signed [31:0] motor_angle;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// expected rotor results, oldest first
	rotor_t expected_rotor[$];
	int fail_count = 0;

	// quiet_mode switches off idling on both sides
	bit quiet_mode = 1'b0;
	// receiver hold-off: requested by a test, counted down by the receiver
	int hold_req = 0;
	int hold_left = 0;

	// held load and target for the well-formed random runs
	logic signed [31:0] held_load = '0;
	logic signed [31:0] held_target = '0;

	// plant model copy of the configuration registers
	logic [30:0] flux_q = '0;
	logic [6:0] poles_q = '0;
	logic [30:0] inv_j_q = '0;
	logic [30:0] kp_q = '0;
	logic [30:0] ki_q = '0;

	// plant model copy of the five states, held wider than the data path
	longint cur_loop_q = 0;
	longint accel_q = 0;
	longint integ_q = 0;
	longint pi_prev_q = 0;
	longint angle_prev_q = 0;

	pmsm_speed_loop_model_step_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation(operation),
		.load_torque(load_torque),
		.speed_target(speed_target),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.motor_speed(motor_speed),
		.motor_angle(motor_angle),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// saturate to the data path range
	function automatic longint clamp_sig(input longint x);
		if (x > SIG_MAX) return SIG_MAX;
		if (x < SIG_MIN) return SIG_MIN;
		return x;
	endfunction

	// exact product, magnitude rounded half away from zero at the shift,
	// then saturated to the data path range
	function automatic longint fx_mul(input longint a, input longint b, input int sh);
		logic neg;
		logic [127:0] ma;
		logic [127:0] mb;
		logic [127:0] prod;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? 128'(-a) : 128'(a);
		mb = (b < 0) ? 128'(-b) : 128'(b);
		prod = ma * mb;
		if (sh > 0)
			prod = (prod + (128'd1 << (sh - 1))) >> sh;
		if (neg) begin
			if (prod > 128'(SIG_MAX))
				return SIG_MIN;
			return -longint'(prod);
		end
		if (prod > 128'(SIG_MAX))
			return SIG_MAX;
		return longint'(prod);
	endfunction

	// output ports are 32 bits whatever the data path width
	function automatic logic signed [31:0] to_port(input longint x);
		if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (x < -64'sd2147483648) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	// advance the plant model by one item and return the rotor result
	function automatic rotor_t step_rotor(input logic op, input logic signed [31:0] load_in,
			input logic signed [31:0] target_in);
		longint load;
		longint target;
		longint torque;
		longint p;
		longint speed;
		longint err;
		longint e;
		longint a;
		longint angle;
		rotor_t r;
		if (op == OP_CLEAR) begin
			cur_loop_q = 0;
			accel_q = 0;
			integ_q = 0;
			pi_prev_q = 0;
			angle_prev_q = 0;
			r.speed = '0;
			r.angle = '0;
			return r;
		end
		load = clamp_sig(longint'(load_in));
		target = clamp_sig(longint'(target_in));

		// electromagnetic torque 0.75*(u+1)*pole_pairs*flux
		torque = clamp_sig(cur_loop_q + longint'(K_ONE));
		torque = fx_mul(torque, longint'(K_075), 16);
		torque = fx_mul(torque, longint'(poles_q), 0);
		torque = fx_mul(torque, longint'(flux_q), 16);

		// trapezoid integration of the net torque into speed
		p = clamp_sig(clamp_sig(torque - load) + accel_q);
		speed = fx_mul(p + accel_q, longint'(K_DT), 32);
		speed = fx_mul(speed, longint'(inv_j_q), 16);

		// pi controller with lag term
		err = clamp_sig(target - speed);
		e = clamp_sig(fx_mul(err, longint'(kp_q), 16) + integ_q
			- fx_mul(pi_prev_q, longint'(K_025), 16));

		// speed integrated into angle
		a = clamp_sig(speed + angle_prev_q);
		angle = fx_mul(a + angle_prev_q, longint'(K_DT), 32);

		cur_loop_q = fx_mul(e + pi_prev_q, longint'(K_0625), 16);
		accel_q = p;
		integ_q = clamp_sig(integ_q
			+ fx_mul(fx_mul(err, longint'(ki_q), 16), longint'(K_KI), 32));
		pi_prev_q = e;
		angle_prev_q = a;

		r.speed = to_port(speed);
		r.angle = to_port(angle);
		return r;
	endfunction

	// mostly small signals, sometimes full range or the extremes
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
		endcase
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
				name, want, want, got, got);
			fail_count++;
		end
	endtask

	// receiver: random stalls, or a long hold-off when a test asks for one
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= quiet_mode || ($urandom_range(99) >= 6);
		end
	end

	// every accepted result against the oldest expectation
	always @(posedge clk) begin : rotor_check
		rotor_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_rotor.size() == 0) begin
				$error("result with nothing expected: speed %0d angle %0d",
					motor_speed, motor_angle);
				fail_count++;
			end else begin
				want = expected_rotor.pop_front();
				check_field("motor_speed", want.speed, motor_speed);
				check_field("motor_angle", want.angle, motor_angle);
			end
		end
	end

	// two-phase apb write, then the bus idles; the model copy follows the register
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FLUX: flux_q = value[30:0];
			REG_POLES: poles_q = value[6:0];
			REG_INV_J: inv_j_q = value[30:0];
			REG_KP: kp_q = value[30:0];
			REG_KI: ki_q = value[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(input logic [31:0] flux, input logic [31:0] poles,
			input logic [31:0] inv_j, input logic [31:0] kp, input logic [31:0] ki);
		write_reg(REG_FLUX, flux);
		write_reg(REG_POLES, poles);
		write_reg(REG_INV_J, inv_j);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
	endtask

	// offer one item, wait for acceptance, record the expected rotor result;
	// valid stays high into the next call unless the sender idles
	task automatic send_item(input logic op, input logic signed [31:0] load,
			input logic signed [31:0] target);
		item_valid <= 1'b1;
		operation <= op;
		load_torque <= load;
		speed_target <= target;
		do @(posedge clk); while (!item_ready);
		expected_rotor.push_back(step_rotor(op, load, target));
		if (!quiet_mode && $urandom_range(99) < 6) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// stop offering and let every expected result come back
	task automatic drain();
		item_valid <= 1'b0;
		while (expected_rotor.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// random items: mostly runs with a held load and target, some noise and clears
	task automatic send_random_items(input int count);
		logic op;
		for (int n = 0; n < count; n++) begin
			op = ($urandom_range(99) < 3) ? OP_CLEAR : OP_TICK;
			if ($urandom_range(99) < 5)
				held_load = pick_value();
			if ($urandom_range(99) < 5)
				held_target = pick_value();
			if ($urandom_range(99) < 10)
				send_item(op, $urandom, pick_value());
			else
				send_item(op, held_load + $signed($urandom_range(0, 255)) - 32'sd128,
					held_target);
		end
	endtask

	// registers at reset are all zero, so zero inverse inertia holds speed at zero
	task automatic test_reset_defaults();
		send_item(OP_TICK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_item(OP_TICK, 32'sh8000_0000, 32'sh8000_0000);
		send_item(OP_CLEAR, 32'sh1234_5678, -32'sd1);
		send_item(OP_TICK, 32'sd0, 32'sd0);
		drain();
	endtask

	// a write past the last register must leave the model untouched
	task automatic test_spare_register();
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		send_item(OP_TICK, -32'sd65536, 32'sd655360);
		send_item(OP_TICK, 32'sd65536, -32'sd655360);
		drain();
	endtask

	// realistic motor, field extremes and a clear in the middle
	task automatic test_field_extremes();
		write_all(32'd655, 32'd4, 32'd65_536_000, 32'd32768, 32'd655360);
		send_item(OP_TICK, 32'sd0, 32'sh7FFF_FFFF);
		send_item(OP_TICK, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_item(OP_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_item(OP_TICK, -32'sd1, 32'sd0);
		send_item(OP_CLEAR, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_item(OP_TICK, 32'sd0, 32'sd6553600);
		send_item(OP_TICK, 32'sd0, 32'sd6553600);
		send_item(OP_TICK, 32'sd32768, -32'sd1);
		drain();
	endtask

	// every register at its top value but pole pairs at 64, then pole pairs and flux at zero
	task automatic test_config_extremes();
		write_all(32'h7FFF_FFFF, 32'd64, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(OP_TICK, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_item(OP_TICK, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_item(OP_TICK, 32'sd0, 32'sd0);
		drain();
		write_all(32'd0, 32'd0, 32'h7FFF_FFFF, 32'd1, 32'd1);
		send_item(OP_TICK, 32'sd65536, 32'sd65536);
		send_item(OP_TICK, 32'sh8000_0000, -32'sd65536);
		drain();
	endtask

	// several register settings, each followed by a random run
	task automatic test_random_settings();
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_all(32'd655 + $urandom_range(0, 6000), 32'd4, 32'd65_536_000,
					32'd32768, 32'd655360);
				1: write_all($urandom & 32'h7FFF_FFFF, $urandom_range(0, 64),
					$urandom & 32'h7FFF_FFFF, $urandom & 32'h7FFF_FFFF,
					$urandom & 32'h7FFF_FFFF);
				2: write_all($urandom_range(1, 1 << 17), $urandom_range(1, 8),
					$urandom_range(0, 1 << 24), $urandom_range(0, 1 << 18),
					$urandom_range(0, 1 << 22));
				3: write_all(32'h7FFF_FFFF, 32'd64, $urandom_range(0, 1 << 12),
					$urandom_range(0, 1 << 16), $urandom_range(0, 1 << 16));
				default: write_all($urandom & 32'h7FFF_FFFF, $urandom_range(0, 64), 32'd0,
					$urandom & 32'h7FFF_FFFF, $urandom & 32'h7FFF_FFFF);
			endcase
			send_random_items(280);
			drain();
		end
	endtask

	// no idling on either side for a stretch
	task automatic test_steady_stream();
		write_all(32'd1311, 32'd2, 32'd32_768_000, 32'd65536, 32'd327680);
		quiet_mode = 1'b1;
		send_random_items(120);
		drain();
		quiet_mode = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering, so the block
	// fills its output register and stalls item_ready
	task automatic test_backpressure();
		quiet_mode = 1'b1;
		hold_req = 1500;
		send_random_items(40);
		drain();
		quiet_mode = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_spare_register();
		test_field_extremes();
		test_config_extremes();
		test_random_settings();
		test_steady_stream();
		test_backpressure();

		// late or extra results show up in the checker during this wait
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hang guard, well beyond the slowest correct run
	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
